[rtl/dopq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dopq_pkg: shared types and constants for the date-ordered priority queue
// Holds the entry layout, the operation and status codes, the cell control
// struct and the date-key function used by every cell.
// ----------------------------------------------------------------------------
package dopq_pkg;

    // Default number of entries the queue can hold.
    localparam int DEPTH_DEFAULT = 16;

    // Field widths of one entry.
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int TAG_W   = 16;
    localparam int KEY_W   = YEAR_W + MONTH_W + DAY_W;
    localparam int OCC_W   = 5;

    // Operation requested by an input transaction.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POP    = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    // Operation broadcast to the row of cells.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } cell_op_t;

    // One stored entry.
    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Control seen by each cell: the operation and whether the head cell
    // has already claimed the new entry (which moves everything down).
    typedef struct packed {
        cell_op_t op;
        logic     front;
    } cell_ctl_t;

    // Since day and month always stay below 100, ordering by
    // year*10000 + month*100 + day equals ordering the concatenation.
    function automatic logic [KEY_W-1:0] entry_key(input entry_t e);
        entry_key = {e.year, e.month, e.day};
    endfunction

endpackage
`default_nettype wire

[rtl/dopq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dopq_cell: one slot of the sorted queue
// Holds one entry and its valid bit. On an insert it keeps its entry, takes
// the new entry, or takes its left neighbor's entry; on a pop it takes its
// right neighbor's entry.
// ----------------------------------------------------------------------------
module dopq_cell
    import dopq_pkg::*;
#(
    parameter bit IS_HEAD = 1'b0
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_valid,
    input  wire logic      left_shift,
    input  wire entry_t    right_entry,
    input  wire logic      right_valid,
    output entry_t         entry,
    output logic           valid,
    output logic           shift
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;
    logic   key_hit;

    // The head takes a new entry whose key is no greater than its own;
    // later cells move aside for a strictly greater stored key, or when the head shifts.
    // An empty cell always lies at or after the insertion point.
    always_comb begin
        if (IS_HEAD) begin
            key_hit = entry_key(entry_reg) >= entry_key(new_entry);
        end else begin
            key_hit = entry_key(entry_reg) > entry_key(new_entry);
        end
        shift = !valid_reg || key_hit || ctl.front;
    end

    // Next entry and valid bit.
    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        case (ctl.op)
            CELL_INSERT: begin
                if (shift && !left_shift) begin
                    entry_next = new_entry;
                    valid_next = 1'b1;
                end else if (shift) begin
                    entry_next = left_entry;
                    valid_next = left_valid;
                end
            end
            CELL_POP: begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
            default: begin
                entry_next = entry_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Entry payload needs no reset; the valid bit does.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule
`default_nettype wire

[rtl/date_ordered_priority_queue_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// date_ordered_priority_queue_core: sorted priority queue keyed by date
// Keeps up to DEPTH entries in a row of cells sorted by (year, month, day).
// An insert places the entry in order; a pop returns the earliest entry.
//
//   Channel  Direction  Ports                                       Beat
//   s_       in         s_mode s_day s_month s_year s_tag           one op
//   m_       out        m_status m_out_* m_occupancy                one result
//
// All cells compare the new key in parallel and move their entries in the
// same clock edge, so one item can be accepted each cycle while the result
// register drains.
// Reset clears the cell valid bits, the entry count and the result valid flag.
// A stalled result holds s_ready low until m_ready takes it.
// ----------------------------------------------------------------------------
module date_ordered_priority_queue_core
    import dopq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    input  wire logic [DAY_W-1:0]   s_day,
    input  wire logic [MONTH_W-1:0] s_month,
    input  wire logic [YEAR_W-1:0]  s_year,
    input  wire logic [TAG_W-1:0]   s_tag,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [DAY_W-1:0]        m_out_day,
    output logic [MONTH_W-1:0]      m_out_month,
    output logic [YEAR_W-1:0]       m_out_year,
    output logic [TAG_W-1:0]        m_out_tag,
    output logic [OCC_W-1:0]        m_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic             accept;
    logic             is_full;
    logic             is_empty;
    cell_op_t         op;
    entry_t           new_entry;
    entry_t           cell_entry [DEPTH];
    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_shift;

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    status_t          status_reg, status_next;
    entry_t           out_entry_reg, out_entry_next;
    logic [CNT_W-1:0] occ_reg, occ_next;
    logic [CNT_W+OCC_W-1:0] occ_wide;

    // Input side accepts whenever the result register is free or draining.
    assign s_ready  = !out_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign is_full  = count_reg == CNT_W'(DEPTH);
    assign is_empty = count_reg == '0;

    assign new_entry.day   = s_day;
    assign new_entry.month = s_month;
    assign new_entry.year  = s_year;
    assign new_entry.tag   = s_tag;

    // Decode the operation for the cells.
    always_comb begin
        op = CELL_HOLD;
        if (accept) begin
            if (s_mode == MODE_INSERT) begin
                op = is_full ? CELL_HOLD : CELL_INSERT;
            end else begin
                op = is_empty ? CELL_HOLD : CELL_POP;
            end
        end
    end

    // Row of cells with neighbor connections.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        cell_ctl_t ctl;
        entry_t    left_entry;
        logic      left_valid;
        logic      left_shift;
        entry_t    right_entry;
        logic      right_valid;

        if (i == 0) begin : g_head
            assign ctl.front  = 1'b0;
            assign left_entry = new_entry;
            assign left_valid = 1'b0;
            assign left_shift = 1'b0;
        end else begin : g_body
            assign ctl.front  = cell_shift[0];
            assign left_entry = cell_entry[i-1];
            assign left_valid = cell_valid[i-1];
            assign left_shift = cell_shift[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_entry = new_entry;
            assign right_valid = 1'b0;
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
            assign right_valid = cell_valid[i+1];
        end

        assign ctl.op = op;

        dopq_cell #(
            .IS_HEAD (i == 0)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .new_entry   (new_entry),
            .left_entry  (left_entry),
            .left_valid  (left_valid),
            .left_shift  (left_shift),
            .right_entry (right_entry),
            .right_valid (right_valid),
            .entry       (cell_entry[i]),
            .valid       (cell_valid[i]),
            .shift       (cell_shift[i])
        );
    end

    // Entry count and result register.
    always_comb begin
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        out_entry_next = out_entry_reg;
        occ_next       = occ_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept) begin
            out_valid_next = 1'b1;
            status_next    = STAT_OK;
            out_entry_next = '0;
            case (op)
                CELL_INSERT: count_next = count_reg + CNT_W'(1);
                CELL_POP: begin
                    count_next     = count_reg - CNT_W'(1);
                    out_entry_next = cell_entry[0];
                end
                default: begin
                    status_next = (s_mode == MODE_INSERT) ? STAT_FULL : STAT_EMPTY;
                end
            endcase
            occ_next = count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        out_entry_reg <= out_entry_next;
        occ_reg       <= occ_next;
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Occupancy carries the count masked to its field width.
    assign occ_wide = {{OCC_W{1'b0}}, occ_reg};

    assign m_valid     = out_valid_reg;
    assign m_status    = status_reg;
    assign m_out_day   = out_entry_reg.day;
    assign m_out_month = out_entry_reg.month;
    assign m_out_year  = out_entry_reg.year;
    assign m_out_tag   = out_entry_reg.tag;
    assign m_occupancy = occ_wide[OCC_W-1:0];

endmodule
`default_nettype wire
